>>> sv/slf_pkg.sv
// Shared types, constants and a helper function of the spectral lattice filter.
package slf_pkg;

  localparam int MAX_STAGES_DEF = 4;
  localparam int MAX_BINS_DEF   = 1024;
  localparam int COEF_REGS      = 4;
  localparam int DATA_W         = 32;
  localparam int COEF_W         = 31;
  localparam int PROD_W         = DATA_W + COEF_W;
  localparam int Q_SHIFT        = 30;
  localparam int ORDER_W        = 3;
  localparam int START_W        = 10;
  localparam int HEAD_W         = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 31;
  localparam logic [START_W-1:0] START_BIN_RST = START_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_ORDER = 3'd1,
    REG_START = 3'd2,
    REG_COEF0 = 3'd3,
    REG_COEF1 = 3'd4,
    REG_COEF2 = 3'd5,
    REG_COEF3 = 3'd6
  } slf_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_EMIT
  } slf_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
    logic emit;
    logic pend;
  } slf_cmd_t;

  typedef struct packed {
    logic filt;
    logic out_free;
  } slf_status_t;

  typedef logic signed [COEF_W-1:0] slf_coef_t;

  function automatic logic [HEAD_W-1:0] headroom_of(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] w;
    logic [HEAD_W-1:0] n;
    int s;
    w = v;
    n = '0;
    s = 0;
    if (v == '0) begin
      return HEAD_W'(31);
    end
    for (int j = 4; j >= 0; j--) begin
      s = 1 << j;
      if ((w >> (DATA_W - s)) == '0) begin
        n = n + HEAD_W'(s);
        w = w << s;
      end
    end
    return (n == '0) ? '0 : n - HEAD_W'(1);
  endfunction

endpackage

>>> sv/slf_in_if.sv
// Input channel: one spectral bin per transaction.
interface slf_in_if;
  import slf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] bin_value;
  logic                     frame_end;

  modport source (output valid, output bin_value, output frame_end, input ready);
  modport sink (input valid, input bin_value, input frame_end, output ready);
endinterface

>>> sv/slf_out_if.sv
// Result channel: one filtered bin per transaction.
interface slf_out_if;
  import slf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered_value;
  logic [HEAD_W-1:0]        frame_headroom;
  logic                     frame_last;

  modport source (output valid, output filtered_value, output frame_headroom,
                  output frame_last, input ready);
  modport sink (input valid, input filtered_value, input frame_headroom,
                input frame_last, output ready);
endinterface

>>> sv/spectral_lattice_filter.sv
// Top level of the spectral lattice filter: configuration registers, controller and datapath.
//
//   channel   direction  transaction
//   in_ch     sink       one bin: bin_value, frame_end
//   out_ch    source     one result: filtered_value, frame_headroom, frame_last
//   cfg_*     write      register index and data, taken whenever cfg_we is high
//
// Bins below start_bin, or with order 0, are accepted and then emitted without lattice steps.
// Filtered bins run order lattice stages between accept and emit; synthesis adds a flush step
// when order exceeds 1. The stages run one lattice stage a cycle on the two shared multipliers.
// Synchronous active-low reset; no clearing pass.
// A stalled result holds in the output register; the next bin waits for its slot.
module spectral_lattice_filter
  import slf_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  parameter int MAX_BINS   = MAX_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  slf_in_if.sink                in_ch,
  slf_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  logic               filter_mode_r;
  logic [ORDER_W-1:0] filter_order_r;
  logic [START_W-1:0] start_bin_r;
  slf_coef_t          coef_r [COEF_REGS];
  logic [ORDER_W-1:0] order_eff;
  slf_cmd_t           cmd;
  slf_status_t        status;
  logic [STG_W-1:0]   idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= 1'b0;
      filter_order_r <= '0;
      start_bin_r    <= START_BIN_RST;
      for (int j = 0; j < COEF_REGS; j++) begin
        coef_r[j] <= '0;
      end
    end else if (cfg_we) begin
      case (slf_reg_t'(cfg_index))
        REG_MODE:  filter_mode_r  <= cfg_wdata[0];
        REG_ORDER: filter_order_r <= cfg_wdata[ORDER_W-1:0];
        REG_START: start_bin_r    <= cfg_wdata[START_W-1:0];
        REG_COEF0: coef_r[0]      <= cfg_wdata[COEF_W-1:0];
        REG_COEF1: coef_r[1]      <= cfg_wdata[COEF_W-1:0];
        REG_COEF2: coef_r[2]      <= cfg_wdata[COEF_W-1:0];
        REG_COEF3: coef_r[3]      <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign order_eff = (int'(filter_order_r) > MAX_STAGES) ? ORDER_W'(MAX_STAGES)
                                                         : filter_order_r;

  slf_ctrl #(
    .MAX_STAGES(MAX_STAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .mode_i   (filter_mode_r),
    .order_eff(order_eff),
    .status   (status),
    .cmd      (cmd),
    .idx      (idx)
  );

  slf_dp #(
    .MAX_STAGES(MAX_STAGES),
    .MAX_BINS  (MAX_BINS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .idx         (idx),
    .status      (status),
    .mode_i      (filter_mode_r),
    .start_bin   (start_bin_r),
    .coef        (coef_r),
    .in_value    (in_ch.bin_value),
    .in_last     (in_ch.frame_end),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_value   (out_ch.filtered_value),
    .out_headroom(out_ch.frame_headroom),
    .out_last    (out_ch.frame_last)
  );

endmodule

>>> sv/slf_ctrl.sv
// Controller state machine sequencing the lattice stages of one bin.
module slf_ctrl
  import slf_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode_i,
  input  logic [ORDER_W-1:0] order_eff,
  input  slf_status_t        status,
  output slf_cmd_t           cmd,
  output logic [STG_W-1:0]   idx
);

  slf_state_t       state_r, state_nxt;
  logic [STG_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             stage_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign stage_end = mode_i ? (idx_r == '0)
                            : (int'(idx_r) == int'(order_eff) - 1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    cmd.pend  = pend_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          pend_nxt = 1'b0;
          if (status.filt && order_eff != '0) begin
            idx_nxt   = mode_i ? STG_W'(order_eff - ORDER_W'(1)) : '0;
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (idx_r != STG_W'(order_eff - ORDER_W'(1))) begin
          pend_nxt = 1'b1;
        end
        if (stage_end) begin
          state_nxt = (mode_i && order_eff > ORDER_W'(1)) ? ST_FLUSH : ST_EMIT;
        end else begin
          idx_nxt = mode_i ? idx_r - STG_W'(1) : idx_r + STG_W'(1);
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idx = idx_r;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("emit while result register is occupied");

  a_flush_synth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> mode_i)
    else $error("flush outside synthesis mode");

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load)
    else $error("second transaction taken before the first finished");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (int'(idx_r) < int'(order_eff)))
    else $error("stage index beyond filter order");

endmodule

>>> sv/slf_dp.sv
// Datapath: lattice delay line, two shared Q30 multipliers, frame state and result register.
module slf_dp
  import slf_pkg::*;
#(
  parameter int MAX_STAGES = MAX_STAGES_DEF,
  parameter int MAX_BINS   = MAX_BINS_DEF,
  localparam int STG_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
  localparam int POS_W = $clog2(MAX_BINS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  slf_cmd_t                 cmd,
  input  logic [STG_W-1:0]         idx,
  output slf_status_t              status,
  input  logic                     mode_i,
  input  logic [START_W-1:0]       start_bin,
  input  slf_coef_t                coef [COEF_REGS],
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic [HEAD_W-1:0]        out_headroom,
  output logic                     out_last
);

  logic signed [DATA_W-1:0] delay_r [MAX_STAGES];
  logic signed [DATA_W-1:0] delay_nxt [MAX_STAGES];
  logic signed [DATA_W-1:0] f_r, b_r;
  slf_coef_t                k_r;
  logic                     last_r;
  logic [POS_W-1:0]         pos_r;
  logic [DATA_W-1:0]        mor_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [HEAD_W-1:0]        out_headroom_r;
  logic                     out_last_r;

  logic signed [DATA_W-1:0] d_sel, s_a, s_b, add_b, sum_b, f_step;
  slf_coef_t                k_sel, k_b;
  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic [DATA_W-1:0]        mor_upd;

  always_comb begin
    k_sel = '0;
    for (int j = 0; j < COEF_REGS; j++) begin
      if (int'(idx) == j) begin
        k_sel = coef[j];
      end
    end
  end

  assign d_sel  = delay_r[idx];
  assign prod_a = d_sel * k_sel;
  assign s_a    = prod_a[Q_SHIFT+DATA_W-1:Q_SHIFT];
  assign k_b    = mode_i ? k_r : k_sel;
  assign prod_b = f_r * k_b;
  assign s_b    = prod_b[Q_SHIFT+DATA_W-1:Q_SHIFT];
  assign add_b  = mode_i ? b_r : d_sel;
  assign sum_b  = s_b + add_b;
  assign f_step = mode_i ? f_r - s_a : f_r + s_a;

  assign mor_upd = mor_r | (f_r[DATA_W-1] ? ~f_r : f_r);

  always_comb begin
    for (int e = 0; e < MAX_STAGES; e++) begin
      delay_nxt[e] = delay_r[e];
      if (cmd.emit && last_r) begin
        delay_nxt[e] = '0;
      end else if (cmd.step && !mode_i && e == int'(idx)) begin
        delay_nxt[e] = b_r;
      end else if (cmd.step && mode_i && cmd.pend && e == int'(idx) + 2) begin
        delay_nxt[e] = sum_b;
      end else if (cmd.step && mode_i && idx == '0 && e == 0) begin
        delay_nxt[e] = f_step;
      end else if (cmd.flush && e == 1) begin
        delay_nxt[e] = sum_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < MAX_STAGES; e++) begin
      if (!rst_n) begin
        delay_r[e] <= '0;
      end else begin
        delay_r[e] <= delay_nxt[e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_r    <= in_value;
      b_r    <= in_value;
      last_r <= in_last;
    end else if (cmd.step) begin
      f_r <= f_step;
      b_r <= mode_i ? d_sel : sum_b;
      k_r <= k_sel;
    end
    if (cmd.emit) begin
      out_value_r    <= f_r;
      out_headroom_r <= last_r ? headroom_of(mor_upd) : '0;
      out_last_r     <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      mor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          pos_r <= '0;
          mor_r <= '0;
        end else begin
          mor_r <= mor_upd;
          if (int'(pos_r) < MAX_BINS - 1) begin
            pos_r <= pos_r + POS_W'(1);
          end
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status = '{filt: (int'(pos_r) >= int'(start_bin)),
                    out_free: (!out_valid_r || out_ready)};

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_headroom = out_headroom_r;
  assign out_last     = out_last_r;

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && last_r) |=> (pos_r == '0 && mor_r == '0))
    else $error("frame state not cleared after last bin");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) <= MAX_BINS - 1)
    else $error("bin position beyond saturation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_value_r))
    else $error("pending result lost");

endmodule

>>> test/tb_top.sv
// Testbench for the spectral lattice filter: bit-exact prediction of every filtered bin.
`timescale 1ns / 100ps

module tb_top;
  import slf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 300;
  localparam int OVERLONG_LEN  = 1030;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(7);
  localparam logic [START_W-1:0]   LAST_POS = START_W'(MAX_BINS_DEF - 1);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } bin_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [HEAD_W-1:0] headroom;
    logic              last;
  } bin_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  slf_in_if  bin_bus ();
  slf_out_if res_bus ();

  spectral_lattice_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (bin_bus),
    .out_ch    (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bin_item_t   bins_to_send[$];
  bin_result_t filtered_due[$];
  bin_item_t   next_bin;
  bin_result_t seen;
  bin_result_t want;

  logic                  m_mode;
  logic [ORDER_W-1:0]    m_order;
  logic [START_W-1:0]    m_start;
  slf_coef_t             m_coef [COEF_REGS];
  logic [DATA_W-1:0]     m_delay [MAX_STAGES_DEF];
  logic [START_W-1:0]    m_pos;
  logic [DATA_W-1:0]     m_mag;

  bit gaps_on;
  bit hold_done;
  int send_gap;
  int stall_left;
  int hold_left;
  int results_seen;
  int mismatches;
  int bins_queued;
  int cycles;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] q30_mul(input logic [DATA_W-1:0] a,
                                                 input logic [COEF_W-1:0] k);
    logic signed [PROD_W-1:0] p;
    p = $signed(a) * $signed(k);
    return p[Q_SHIFT+DATA_W-1:Q_SHIFT];
  endfunction

  function automatic logic [HEAD_W-1:0] sign_bits(input logic [DATA_W-1:0] x);
    int n;
    n = 0;
    while (n < DATA_W && x[DATA_W-1-n] == 1'b0) n++;
    return (n == 0) ? '0 : HEAD_W'(n - 1);
  endfunction

  function automatic void filter_bin(input logic [DATA_W-1:0] x, input logic last);
    logic [DATA_W-1:0] y, f, bprev, bold, fnext;
    int ord, i;
    bin_result_t r;
    ord = (m_order > MAX_STAGES_DEF) ? MAX_STAGES_DEF : int'(m_order);
    y = x;
    if (m_pos >= m_start && ord > 0) begin
      if (!m_mode) begin
        f = x;
        bprev = x;
        for (i = 0; i < ord; i++) begin
          bold = m_delay[i];
          fnext = f + q30_mul(bold, m_coef[i]);
          m_delay[i] = bprev;
          bprev = q30_mul(f, m_coef[i]) + bold;
          f = fnext;
        end
      end else begin
        f = x - q30_mul(m_delay[ord-1], m_coef[ord-1]);
        for (i = ord - 2; i >= 0; i--) begin
          f = f - q30_mul(m_delay[i], m_coef[i]);
          m_delay[i+1] = q30_mul(f, m_coef[i]) + m_delay[i];
        end
        m_delay[0] = f;
      end
      y = f;
    end
    m_mag |= y[DATA_W-1] ? ~y : y;
    r.value = y;
    r.headroom = last ? sign_bits(m_mag) : '0;
    r.last = last;
    filtered_due.push_back(r);
    if (last) begin
      foreach (m_delay[j]) m_delay[j] = '0;
      m_pos = '0;
      m_mag = '0;
    end else if (m_pos != LAST_POS) begin
      m_pos++;
    end
  endfunction

  // driver: offer bins, predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      bin_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (bin_bus.valid && bin_bus.ready) filter_bin(bin_bus.bin_value, bin_bus.frame_end);
      if (!bin_bus.valid || bin_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          bin_bus.valid <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 7);
          bin_bus.valid <= 1'b0;
        end else if (bins_to_send.size() != 0) begin
          next_bin = bins_to_send.pop_front();
          bin_bus.valid <= 1'b1;
          bin_bus.bin_value <= next_bin.value;
          bin_bus.frame_end <= next_bin.last;
        end else begin
          bin_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare results, stall at random, hold off once for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        seen.value = res_bus.filtered_value;
        seen.headroom = res_bus.frame_headroom;
        seen.last = res_bus.frame_last;
        results_seen++;
        if (filtered_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, actual value %h headroom %0d last %0b",
                   $time, seen.value, seen.headroom, seen.last);
        end else begin
          want = filtered_due.pop_front();
          if (seen.value !== want.value) begin
            mismatches++;
            $display("%0t: filtered_value expected %h actual %h",
                     $time, want.value, seen.value);
          end
          if (seen.headroom !== want.headroom) begin
            mismatches++;
            $display("%0t: frame_headroom expected %0d actual %0d",
                     $time, want.headroom, seen.headroom);
          end
          if (seen.last !== want.last) begin
            mismatches++;
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, want.last, seen.last);
          end
        end
      end
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    case (idx)
      REG_MODE:  m_mode = d[0];
      REG_ORDER: m_order = d[ORDER_W-1:0];
      REG_START: m_start = d[START_W-1:0];
      REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3: m_coef[idx - REG_COEF0] = d;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (bins_to_send.size() != 0 || bin_bus.valid || filtered_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_bin(input logic [DATA_W-1:0] v, input logic last);
    bin_item_t b;
    b.value = v;
    b.last = last;
    bins_to_send.push_back(b);
    bins_queued++;
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: begin
        v = $urandom() >> $urandom_range(1, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: case ($urandom_range(0, 3))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = '0;
        default: v = '1;
      endcase
      default: v = DATA_W'($urandom_range(0, 4000)) - DATA_W'(2000);
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coef(input bit moderate);
    logic [DATA_W-1:0] v;
    v = $urandom_range(0, 32'h2FFF_FFFF);
    if ($urandom_range(0, 1)) v = -v;
    if (!moderate) begin
      case ($urandom_range(0, 3))
        0: v = $urandom();
        1: v = $urandom_range(0, 1) ? 32'h3FFF_FFFF : 32'h4000_0000;
        default: ;
      endcase
    end
    return v[CFG_DATA_W-1:0];
  endfunction

  function automatic void push_random_frames(input int n);
    int left, len, j;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 24);
      for (j = 0; j < len && left > 0; j++) begin
        push_bin(rand_value(), j == len - 1);
        left--;
      end
    end
  endfunction

  task automatic random_setup();
    int s;
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    case ($urandom_range(0, 9))
      0: write_reg(REG_ORDER, '0);
      1: write_reg(REG_ORDER, CFG_DATA_W'($urandom_range(5, 7)));
      default: write_reg(REG_ORDER, CFG_DATA_W'($urandom_range(1, 4)));
    endcase
    case ($urandom_range(0, 9))
      0: write_reg(REG_START, CFG_DATA_W'(LAST_POS));
      1: write_reg(REG_START, CFG_DATA_W'($urandom_range(9, 1023)));
      default: write_reg(REG_START, CFG_DATA_W'($urandom_range(0, 8)));
    endcase
    for (s = 0; s < COEF_REGS; s++) write_reg(CFG_IDX_W'(REG_COEF0 + s), rand_coef(1'b0));
    if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom()));
    end_writes();
  endtask

  initial begin
    int s, j;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    bin_bus.valid = 1'b0;
    bin_bus.bin_value = '0;
    bin_bus.frame_end = 1'b0;
    res_bus.ready = 1'b0;
    m_mode = 1'b0;
    m_order = '0;
    m_start = START_BIN_RST;
    foreach (m_coef[i]) m_coef[i] = '0;
    foreach (m_delay[i]) m_delay[i] = '0;
    m_pos = '0;
    m_mag = '0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: pass through, extreme values, an all-zero frame and an all-ones bin
    push_bin(32'h7FFF_FFFF, 1'b0);
    push_bin(32'h8000_0000, 1'b0);
    push_bin(32'h0000_0001, 1'b1);
    push_bin(32'h0000_0000, 1'b1);
    push_bin(32'hFFFF_FFFF, 1'b0);
    push_bin(32'h0000_0000, 1'b1);
    settle();

    // analysis at full order with extreme coefficients: wrap on overflow
    write_reg(REG_MODE, '0);
    write_reg(REG_ORDER, CFG_DATA_W'(4));
    write_reg(REG_START, '0);
    write_reg(REG_COEF0, 31'h3FFF_FFFF);
    write_reg(REG_COEF1, 31'h4000_0000);
    write_reg(REG_COEF2, 31'h2000_0000);
    write_reg(REG_COEF3, 31'h6000_0000);
    end_writes();
    push_bin(32'h7FFF_FFFF, 1'b0);
    push_bin(32'h8000_0000, 1'b0);
    push_bin(32'h7FFF_FFFF, 1'b0);
    push_bin(32'h8000_0000, 1'b0);
    push_bin(32'h1234_5678, 1'b0);
    push_bin(32'hFFFF_FFFF, 1'b0);
    push_bin(32'h0000_0000, 1'b0);
    push_bin(32'h8000_0000, 1'b1);
    settle();

    // synthesis with saturated order, late start, ignored register index
    write_reg(REG_MODE, CFG_DATA_W'(1));
    write_reg(REG_ORDER, CFG_DATA_W'(7));
    write_reg(REG_START, CFG_DATA_W'(2));
    write_reg(REG_NONE, '1);
    for (s = 0; s < COEF_REGS; s++) write_reg(CFG_IDX_W'(REG_COEF0 + s), rand_coef(1'b1));
    end_writes();
    push_bin(32'h4000_0000, 1'b0);
    push_bin(32'hC000_0000, 1'b0);
    push_bin(32'h7FFF_FFFF, 1'b0);
    push_bin(32'h8000_0000, 1'b0);
    push_bin(32'h0000_0001, 1'b0);
    push_bin(32'hFFFF_FFFF, 1'b1);
    push_bin(32'h0000_0005, 1'b0);
    push_bin(32'hFFFF_FFFB, 1'b0);
    settle();

    // overlong frame: position saturates at the last bin index
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(REG_ORDER, CFG_DATA_W'(4));
    write_reg(REG_START, CFG_DATA_W'(LAST_POS - 3));
    for (s = 0; s < COEF_REGS; s++) write_reg(CFG_IDX_W'(REG_COEF0 + s), rand_coef(1'b1));
    end_writes();
    for (j = 0; j < OVERLONG_LEN; j++) push_bin(rand_value(), j == OVERLONG_LEN - 1);
    settle();

    while (bins_queued < 1600) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      random_setup();
      push_random_frames($urandom_range(30, 120));
      settle();
    end

    gaps_on = 1'b0;
    random_setup();
    push_random_frames(150);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
